>>> rtl/tre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tre_pkg
// Shared constants for the tiny RISC instruction executor: command codes,
// opcodes, memory request codes, debug register ids and reset values.
// ----------------------------------------------------------------------------
package tre_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned NUM_GPR  = 8;
  localparam int unsigned GPR_AW   = $clog2(NUM_GPR);

  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [7:0] OP_MOVLO = 8'd0;
  localparam logic [7:0] OP_MOVHI = 8'd1;
  localparam logic [7:0] OP_MOVR  = 8'd2;
  localparam logic [7:0] OP_ADD   = 8'd3;
  localparam logic [7:0] OP_SUB   = 8'd4;
  localparam logic [7:0] OP_LD    = 8'd5;
  localparam logic [7:0] OP_ST    = 8'd6;
  localparam logic [7:0] OP_JMP   = 8'd7;
  localparam logic [7:0] OP_BEQ   = 8'd8;
  localparam logic [7:0] OP_BGT   = 8'd9;
  localparam logic [7:0] OP_BLT   = 8'd10;
  localparam logic [7:0] OP_HALT  = 8'd11;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  localparam logic [7:0] ID_PC     = 8'd8;
  localparam logic [7:0] ID_SP     = 8'd9;
  localparam logic [7:0] ID_STATUS = 8'd10;

  localparam logic [XLEN-1:0] PC_RESET = 32'h0000_0100;
  localparam logic [XLEN-1:0] PC_STEP  = 32'd4;

endpackage : tre_pkg
`default_nettype wire

>>> rtl/tre_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tre_ram
// Generic synchronous RAM with one write port and one registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module tre_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule : tre_ram
`default_nettype wire

>>> rtl/tiny_risc_instruction_executor_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tiny_risc_instruction_executor_unit
// Toy 32-bit RISC core: executes one fetched instruction, load return or
// debug register access per beat and reports the resulting core state.
// ----------------------------------------------------------------------------
// The unit takes one beat per clock cycle while the output is not stalled.
// On acceptance the operand addresses are presented to three copies of the
// eight-entry general register file, one per read operand, and the beat is
// registered in stage one; from stage one the instruction is executed, the
// register file is written back and the result is loaded into the output
// register. A value written back by one beat is forwarded to the next beat's
// operands. The general registers read as zero after reset until first
// written, so no clearing pass is needed.
module tiny_risc_instruction_executor_unit
  import tre_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [31:0] in_instruction_word,
  input  wire logic [31:0] in_load_data,
  input  wire logic [7:0]  in_reg_index,
  input  wire logic [31:0] in_reg_write_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_next_pc,
  output logic [1:0]       out_mem_op,
  output logic [31:0]      out_mem_address,
  output logic [31:0]      out_mem_write_value,
  output logic             out_stopped,
  output logic [31:0]      out_reg_read_value,
  output logic [31:0]      out_retired_count
);

  logic              in_acc;
  logic              s1_adv;
  logic [GPR_AW-1:0] rd_addr_in;

  logic              s1_valid_r;
  logic [1:0]        s1_cmd_r;
  logic [31:0]       s1_word_r;
  logic [31:0]       s1_ldata_r;
  logic [7:0]        s1_idx_r;
  logic [31:0]       s1_wval_r;

  logic [XLEN-1:0]   pc_r, pc_nxt;
  logic [XLEN-1:0]   sp_r, sp_nxt;
  logic [XLEN-1:0]   status_r, status_nxt;
  logic              halted_r, halted_nxt;
  logic              ld_pend_r, ld_pend_nxt;
  logic [GPR_AW-1:0] ld_dest_r, ld_dest_nxt;
  logic [XLEN-1:0]   cnt_r, cnt_nxt;
  logic [NUM_GPR-1:0] gpr_vld_r;

  logic              byp_vld_r;
  logic [GPR_AW-1:0] byp_addr_r;
  logic [XLEN-1:0]   byp_data_r;

  logic              wb_en;
  logic [GPR_AW-1:0] wb_addr;
  logic [XLEN-1:0]   wb_data;

  logic [XLEN-1:0]   q_a, q_b, q_d;
  logic [GPR_AW-1:0] s1_a, s1_b, s1_d;
  logic [XLEN-1:0]   op_a, op_b, op_d;
  logic [7:0]        opcode;
  logic [15:0]       imm;
  logic [XLEN-1:0]   pc_inc;

  logic [1:0]        res_mem_op;
  logic [XLEN-1:0]   res_mem_addr;
  logic [XLEN-1:0]   res_mem_wval;
  logic [XLEN-1:0]   res_rd_val;

  logic              out_valid_r;
  logic [31:0]       out_pc_r, out_addr_r, out_wval_r, out_rd_r, out_cnt_r;
  logic [1:0]        out_op_r;
  logic              out_stop_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  assign rd_addr_in = (in_command == CMD_READ) ? in_reg_index[GPR_AW-1:0]
                                               : in_instruction_word[16 +: GPR_AW];

  tre_ram #(.WIDTH(XLEN), .DEPTH(NUM_GPR)) u_ram_a (
    .clk   (clk),
    .we    (wb_en),
    .waddr (wb_addr),
    .wdata (wb_data),
    .re    (in_acc),
    .raddr (in_instruction_word[8 +: GPR_AW]),
    .rdata (q_a)
  );

  tre_ram #(.WIDTH(XLEN), .DEPTH(NUM_GPR)) u_ram_b (
    .clk   (clk),
    .we    (wb_en),
    .waddr (wb_addr),
    .wdata (wb_data),
    .re    (in_acc),
    .raddr (in_instruction_word[GPR_AW-1:0]),
    .rdata (q_b)
  );

  tre_ram #(.WIDTH(XLEN), .DEPTH(NUM_GPR)) u_ram_d (
    .clk   (clk),
    .we    (wb_en),
    .waddr (wb_addr),
    .wdata (wb_data),
    .re    (in_acc),
    .raddr (rd_addr_in),
    .rdata (q_d)
  );

  // Stage one item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r   <= in_command;
      s1_word_r  <= in_instruction_word;
      s1_ldata_r <= in_load_data;
      s1_idx_r   <= in_reg_index;
      s1_wval_r  <= in_reg_write_value;
    end
  end

  // Operand selection with forwarding of the most recent write-back.
  assign s1_a = s1_word_r[8 +: GPR_AW];
  assign s1_b = s1_word_r[GPR_AW-1:0];
  assign s1_d = (s1_cmd_r == CMD_READ) ? s1_idx_r[GPR_AW-1:0] : s1_word_r[16 +: GPR_AW];

  always_comb begin
    if (byp_vld_r && byp_addr_r == s1_a) begin
      op_a = byp_data_r;
    end else if (gpr_vld_r[s1_a]) begin
      op_a = q_a;
    end else begin
      op_a = '0;
    end
    if (byp_vld_r && byp_addr_r == s1_b) begin
      op_b = byp_data_r;
    end else if (gpr_vld_r[s1_b]) begin
      op_b = q_b;
    end else begin
      op_b = '0;
    end
    if (byp_vld_r && byp_addr_r == s1_d) begin
      op_d = byp_data_r;
    end else if (gpr_vld_r[s1_d]) begin
      op_d = q_d;
    end else begin
      op_d = '0;
    end
  end

  assign opcode = s1_word_r[31:24];
  assign imm    = s1_word_r[15:0];
  assign pc_inc = pc_r + PC_STEP;

  // Execute.
  always_comb begin
    pc_nxt       = pc_r;
    sp_nxt       = sp_r;
    status_nxt   = status_r;
    halted_nxt   = halted_r;
    ld_pend_nxt  = ld_pend_r;
    ld_dest_nxt  = ld_dest_r;
    cnt_nxt      = cnt_r;
    wb_en        = 1'b0;
    wb_addr      = s1_d;
    wb_data      = op_a;
    res_mem_op   = MEM_NONE;
    res_mem_addr = '0;
    res_mem_wval = '0;
    res_rd_val   = '0;
    unique case (s1_cmd_r)
      CMD_EXEC: begin
        if (!halted_r) begin
          pc_nxt  = pc_inc;
          cnt_nxt = cnt_r + 32'd1;
          unique case (opcode)
            OP_MOVLO: begin
              wb_en   = 1'b1;
              wb_data = {op_d[31:16], imm};
            end
            OP_MOVHI: begin
              wb_en   = 1'b1;
              wb_data = {imm, op_d[15:0]};
            end
            OP_MOVR: begin
              wb_en   = 1'b1;
              wb_data = op_a;
            end
            OP_ADD: begin
              wb_en   = 1'b1;
              wb_data = op_a + op_b;
            end
            OP_SUB: begin
              wb_en   = 1'b1;
              wb_data = op_a - op_b;
            end
            OP_LD: begin
              res_mem_op   = MEM_READ;
              res_mem_addr = op_a;
              ld_pend_nxt  = 1'b1;
              ld_dest_nxt  = s1_d;
            end
            OP_ST: begin
              res_mem_op   = MEM_WRITE;
              res_mem_addr = op_d;
              res_mem_wval = op_a;
            end
            OP_JMP: begin
              pc_nxt = op_a;
            end
            OP_BEQ: begin
              if (op_a == op_b) begin
                pc_nxt = op_d;
              end
            end
            OP_BGT: begin
              if (op_a > op_b) begin
                pc_nxt = op_d;
              end
            end
            OP_BLT: begin
              if (op_a < op_b) begin
                pc_nxt = op_d;
              end
            end
            OP_HALT: begin
              pc_nxt     = pc_r;
              halted_nxt = 1'b1;
            end
            default: begin
              halted_nxt = 1'b1;
            end
          endcase
        end
      end
      CMD_LOAD: begin
        if (ld_pend_r) begin
          wb_en       = 1'b1;
          wb_addr     = ld_dest_r;
          wb_data     = s1_ldata_r;
          ld_pend_nxt = 1'b0;
        end
      end
      CMD_WRITE: begin
        priority if (s1_idx_r < 8'(NUM_GPR)) begin
          wb_en   = 1'b1;
          wb_addr = s1_idx_r[GPR_AW-1:0];
          wb_data = s1_wval_r;
        end else if (s1_idx_r == ID_PC) begin
          pc_nxt = s1_wval_r;
        end else if (s1_idx_r == ID_SP) begin
          sp_nxt = s1_wval_r;
        end else if (s1_idx_r == ID_STATUS) begin
          status_nxt = s1_wval_r;
        end else begin
          wb_en = 1'b0;
        end
      end
      default: begin
        priority if (s1_idx_r < 8'(NUM_GPR)) begin
          res_rd_val = op_d;
        end else if (s1_idx_r == ID_PC) begin
          res_rd_val = pc_r;
        end else if (s1_idx_r == ID_SP) begin
          res_rd_val = sp_r;
        end else if (s1_idx_r == ID_STATUS) begin
          res_rd_val = status_r;
        end else begin
          res_rd_val = '1;
        end
      end
    endcase
    if (!s1_adv) begin
      wb_en = 1'b0;
    end
  end

  // Architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= PC_RESET;
      sp_r      <= '0;
      status_r  <= '0;
      halted_r  <= 1'b0;
      ld_pend_r <= 1'b0;
      ld_dest_r <= '0;
      cnt_r     <= '0;
      gpr_vld_r <= '0;
      byp_vld_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        pc_r      <= pc_nxt;
        sp_r      <= sp_nxt;
        status_r  <= status_nxt;
        halted_r  <= halted_nxt;
        ld_pend_r <= ld_pend_nxt;
        ld_dest_r <= ld_dest_nxt;
        cnt_r     <= cnt_nxt;
      end
      if (wb_en) begin
        gpr_vld_r[wb_addr] <= 1'b1;
        byp_vld_r          <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      byp_addr_r <= wb_addr;
      byp_data_r <= wb_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pc_r   <= pc_nxt;
      out_op_r   <= res_mem_op;
      out_addr_r <= res_mem_addr;
      out_wval_r <= res_mem_wval;
      out_stop_r <= halted_nxt;
      out_rd_r   <= res_rd_val;
      out_cnt_r  <= cnt_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_next_pc         = out_pc_r;
  assign out_mem_op          = out_op_r;
  assign out_mem_address     = out_addr_r;
  assign out_mem_write_value = out_wval_r;
  assign out_stopped         = out_stop_r;
  assign out_reg_read_value  = out_rd_r;
  assign out_retired_count   = out_cnt_r;

endmodule : tiny_risc_instruction_executor_unit
`default_nettype wire

>>> rtl/tre_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tre_checker
// Port-level checks for the tiny RISC instruction executor, bound to the
// top level.
// ----------------------------------------------------------------------------
module tre_checker
  import tre_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_next_pc,
  input wire logic [1:0]  out_mem_op,
  input wire logic [31:0] out_mem_address,
  input wire logic [31:0] out_mem_write_value,
  input wire logic        out_stopped,
  input wire logic [31:0] out_retired_count
);

  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result beat valid right after reset.");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc)
      && $stable(out_retired_count) && $stable(out_mem_op))
    else $error("Stalled result beat changed.");

  a_mem_req : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mem_op != 2'd3
      && (out_mem_op != MEM_NONE || (out_mem_address == '0 && out_mem_write_value == '0)))
    else $error("Malformed memory request.");

  a_stop_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_stopped |=> !out_valid || out_stopped)
    else $error("Core left the stopped state without reset.");

  a_ready_free : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("Input stalled while the result side is empty.");

endmodule : tre_checker

bind tiny_risc_instruction_executor_unit tre_checker u_tre_checker (.*);
`default_nettype wire
